// ===== hw/rtl/pcsn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsn_pkg
// Shared constants and types for the cross-spectrum phase normaliser.
// ----------------------------------------------------------------------------
package pcsn_pkg;

  // Default width of one spectrum component and of the phasor fraction.
  localparam int BIN_BITS_DEF  = 24;
  localparam int FRAC_BITS_DEF = 15;

  // Output phasor parts are always 16-bit two's complement.
  localparam int OUT_W   = 16;
  localparam int SAT_MAX = 32767;

  // Control and flags that travel alongside the arithmetic of one item.
  typedef struct packed {
    logic vld;
    logic last;
    logic zero;
    logic neg_re;
    logic neg_im;
  } pcsn_side_t;

endpackage

// ===== hw/rtl/pcsn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsn_front
// Forms the cross products, splits each part into sign and magnitude and
// squares the magnitudes from half-width partial products. Four stages.
// ----------------------------------------------------------------------------
module pcsn_front
  import pcsn_pkg::*;
#(
  parameter int BIN_BITS = BIN_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic signed [BIN_BITS-1:0]   lr,
  input  logic signed [BIN_BITS-1:0]   li,
  input  logic signed [BIN_BITS-1:0]   rr,
  input  logic signed [BIN_BITS-1:0]   ri,
  input  logic                         last,
  output logic [4*BIN_BITS-1:0]        sq_re,
  output logic [4*BIN_BITS-1:0]        sq_im,
  output logic [4*BIN_BITS:0]          pow,
  output pcsn_side_t                   side
);

  localparam int B = BIN_BITS;

  // Stage one: the four component products.
  logic signed [2*B-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                  v1_r, last1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr_r  <= lr * rr;
      p_ii_r  <= li * ri;
      p_ri_r  <= lr * ri;
      p_ir_r  <= li * rr;
      last1_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  // Stage two: real and imaginary sums, as sign and magnitude.
  logic signed [2*B:0] sre, sim;
  logic [2*B-1:0]      mag_re_nxt, mag_im_nxt;
  logic [2*B-1:0]      mag_re_r, mag_im_r;
  pcsn_side_t          s2_nxt, s2_r;

  always_comb begin
    sre        = (2*B+1)'(p_rr_r) + (2*B+1)'(p_ii_r);
    sim        = (2*B+1)'(p_ri_r) - (2*B+1)'(p_ir_r);
    mag_re_nxt = sre[2*B] ? (2*B)'(-sre) : sre[2*B-1:0];
    mag_im_nxt = sim[2*B] ? (2*B)'(-sim) : sim[2*B-1:0];
    s2_nxt.vld    = v1_r;
    s2_nxt.last   = last1_r;
    s2_nxt.zero   = (sre == '0) && (sim == '0);
    s2_nxt.neg_re = sre[2*B];
    s2_nxt.neg_im = sim[2*B];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_re_r <= mag_re_nxt;
      mag_im_r <= mag_im_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else if (en) begin
      s2_r <= s2_nxt;
    end
  end

  // Stage three: half-width partial products of each square.
  logic [2*B-1:0] hh_re_r, hl_re_r, ll_re_r;
  logic [2*B-1:0] hh_im_r, hl_im_r, ll_im_r;
  pcsn_side_t     s3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hh_re_r <= mag_re_r[2*B-1:B] * mag_re_r[2*B-1:B];
      hl_re_r <= mag_re_r[2*B-1:B] * mag_re_r[B-1:0];
      ll_re_r <= mag_re_r[B-1:0]   * mag_re_r[B-1:0];
      hh_im_r <= mag_im_r[2*B-1:B] * mag_im_r[2*B-1:B];
      hl_im_r <= mag_im_r[2*B-1:B] * mag_im_r[B-1:0];
      ll_im_r <= mag_im_r[B-1:0]   * mag_im_r[B-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r <= '0;
    end else if (en) begin
      s3_r <= s2_r;
    end
  end

  // Stage four: full squares and the power of the cross spectrum.
  logic [4*B-1:0] sq_re_nxt, sq_im_nxt;
  logic [4*B-1:0] sq_re_r, sq_im_r;
  logic [4*B:0]   pow_r;
  pcsn_side_t     s4_r;

  always_comb begin
    sq_re_nxt = {hh_re_r, ll_re_r} + ((4*B)'(hl_re_r) << (B + 1));
    sq_im_nxt = {hh_im_r, ll_im_r} + ((4*B)'(hl_im_r) << (B + 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_re_r <= sq_re_nxt;
      sq_im_r <= sq_im_nxt;
      pow_r   <= (4*B+1)'(sq_re_nxt) + (4*B+1)'(sq_im_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r <= '0;
    end else if (en) begin
      s4_r <= s3_r;
    end
  end

  assign sq_re = sq_re_r;
  assign sq_im = sq_im_r;
  assign pow   = pow_r;
  assign side  = s4_r;

endmodule

// ===== hw/rtl/pcsn_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsn_cell
// Decides one bit of the rounded ratio. It keeps the residual
// D = a^2*4^(F+1) - (2q-1)^2*P and Z = (2q-1)*P and tries q + 2^K.
// ----------------------------------------------------------------------------
module pcsn_cell
  import pcsn_pkg::*;
#(
  parameter int DW = 8,
  parameter int PW = 4,
  parameter int QW = 2,
  parameter int K  = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] d_i,
  input  logic signed [DW-1:0] z_i,
  input  logic [PW-1:0]        p_i,
  input  logic [QW-1:0]        q_i,
  output logic signed [DW-1:0] d_o,
  output logic signed [DW-1:0] z_o,
  output logic [PW-1:0]        p_o,
  output logic [QW-1:0]        q_o
);

  logic signed [DW-1:0] p_ext;
  logic signed [DW-1:0] d_try;
  logic                 take;
  logic signed [DW-1:0] d_nxt, z_nxt;
  logic [QW-1:0]        q_nxt;
  logic signed [DW-1:0] d_r, z_r;
  logic [PW-1:0]        p_r;
  logic [QW-1:0]        q_r;

  // Trial residual for the candidate with bit K set.
  always_comb begin
    p_ext = signed'(DW'(p_i));
    d_try = d_i - (z_i <<< (K + 2)) - (p_ext <<< (2*K + 2));
    take  = !d_try[DW-1];
    d_nxt = take ? d_try : d_i;
    z_nxt = take ? (z_i + (p_ext <<< (K + 1))) : z_i;
    q_nxt = take ? (q_i | (QW'(1) << K)) : q_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
      z_r <= z_nxt;
      p_r <= p_i;
      q_r <= q_nxt;
    end
  end

  assign d_o = d_r;
  assign z_o = z_r;
  assign p_o = p_r;
  assign q_o = q_r;

endmodule

// ===== hw/rtl/phat_cross_spectrum_normalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phat_cross_spectrum_normalizer
// Phase-transform weighting of one cross-spectrum bin: conj(L)*R / (|L||R|)
// as a saturated, rounded Q1.FRAC_BITS phasor.
//
//   channel | ports                                      | direction
//   input   | in_valid/in_ready, in_left_*, in_right_*  | bins in
//   result  | out_valid/out_ready, out_phase_*, flags    | phasors out
//
// One item is accepted per cycle while the pipeline is not held. The pipeline
// is four front stages, one cell per ratio bit and one output register.
// The whole pipeline holds when a result is waiting and out_ready is low.
// Reset clears the valid bits and the side flags; there is no other state between bins.
// ----------------------------------------------------------------------------
module phat_cross_spectrum_normalizer
  import pcsn_pkg::*;
#(
  parameter int BIN_BITS  = BIN_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [BIN_BITS-1:0] in_left_real,
  input  logic signed [BIN_BITS-1:0] in_left_imag,
  input  logic signed [BIN_BITS-1:0] in_right_real,
  input  logic signed [BIN_BITS-1:0] in_right_imag,
  input  logic                       in_last_bin,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_W-1:0]    out_phase_real,
  output logic signed [OUT_W-1:0]    out_phase_imag,
  output logic                       out_zero_magnitude,
  output logic                       out_last_out
);

  localparam int B   = BIN_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 4*B + 1;
  localparam int DW  = 4*B + 2*F + 6;
  localparam int QW  = F + 1;
  localparam int NC  = F + 1;
  localparam int LIM = ((1 << F) - 1 > SAT_MAX) ? SAT_MAX : (1 << F) - 1;

  logic en;
  logic out_valid_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  logic [4*B-1:0] sq_re, sq_im;
  logic [PW-1:0]  pow;
  pcsn_side_t     side_f;

  pcsn_front #(
    .BIN_BITS(B)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_vld(in_valid),
    .lr    (in_left_real),
    .li    (in_left_imag),
    .rr    (in_right_real),
    .ri    (in_right_imag),
    .last  (in_last_bin),
    .sq_re (sq_re),
    .sq_im (sq_im),
    .pow   (pow),
    .side  (side_f)
  );

  // Chain inputs: residual a^2*4^(F+1) - P with q = 0, and Z = -P.
  logic signed [DW-1:0] d_re [NC+1];
  logic signed [DW-1:0] d_im [NC+1];
  logic signed [DW-1:0] z_re [NC+1];
  logic signed [DW-1:0] z_im [NC+1];
  logic [PW-1:0]        p_re [NC+1];
  logic [PW-1:0]        p_im [NC+1];
  logic [QW-1:0]        q_re [NC+1];
  logic [QW-1:0]        q_im [NC+1];
  pcsn_side_t           side_c [NC+1];

  assign d_re[0]   = signed'(DW'(sq_re) << (2*F + 2)) - signed'(DW'(pow));
  assign d_im[0]   = signed'(DW'(sq_im) << (2*F + 2)) - signed'(DW'(pow));
  assign z_re[0]   = -signed'(DW'(pow));
  assign z_im[0]   = -signed'(DW'(pow));
  assign p_re[0]   = pow;
  assign p_im[0]   = pow;
  assign q_re[0]   = '0;
  assign q_im[0]   = '0;
  assign side_c[0] = side_f;

  // One cell per ratio bit, most significant first, for both parts.
  for (genvar i = 0; i < NC; i++) begin : g_cell
    pcsn_cell #(.DW(DW), .PW(PW), .QW(QW), .K(F - i)) u_re (
      .clk(clk), .en(en),
      .d_i(d_re[i]), .z_i(z_re[i]), .p_i(p_re[i]), .q_i(q_re[i]),
      .d_o(d_re[i+1]), .z_o(z_re[i+1]), .p_o(p_re[i+1]), .q_o(q_re[i+1])
    );

    pcsn_cell #(.DW(DW), .PW(PW), .QW(QW), .K(F - i)) u_im (
      .clk(clk), .en(en),
      .d_i(d_im[i]), .z_i(z_im[i]), .p_i(p_im[i]), .q_i(q_im[i]),
      .d_o(d_im[i+1]), .z_o(z_im[i+1]), .p_o(p_im[i+1]), .q_o(q_im[i+1])
    );

    pcsn_side_t side_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r <= '0;
      end else if (en) begin
        side_r <= side_c[i];
      end
    end

    assign side_c[i+1] = side_r;
  end

  // Saturate, apply the sign and force zero for a zero-magnitude bin.
  logic [QW-1:0]           qc_re, qc_im;
  logic signed [OUT_W-1:0] ph_re_nxt, ph_im_nxt;
  logic signed [OUT_W-1:0] ph_re_r, ph_im_r;
  logic                    zero_r, last_r;
  pcsn_side_t              s_end;

  always_comb begin
    s_end     = side_c[NC];
    qc_re     = (q_re[NC] > QW'(LIM)) ? QW'(LIM) : q_re[NC];
    qc_im     = (q_im[NC] > QW'(LIM)) ? QW'(LIM) : q_im[NC];
    ph_re_nxt = s_end.neg_re ? -signed'(OUT_W'(qc_re)) : signed'(OUT_W'(qc_re));
    ph_im_nxt = s_end.neg_im ? -signed'(OUT_W'(qc_im)) : signed'(OUT_W'(qc_im));
    if (s_end.zero) begin
      ph_re_nxt = '0;
      ph_im_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_re_r <= ph_re_nxt;
      ph_im_r <= ph_im_nxt;
      zero_r  <= s_end.zero;
      last_r  <= s_end.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s_end.vld;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_phase_real     = ph_re_r;
  assign out_phase_imag     = ph_im_r;
  assign out_zero_magnitude = zero_r;
  assign out_last_out       = last_r;

endmodule

// ===== dv/phat_cross_spectrum_normalizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phat_cross_spectrum_normalizer_tb
// Self-checking bench for the cross-spectrum phase normaliser. Bins are pushed
// through a valid/ready driver with random gaps. The expected phasor of each
// item is worked out exactly with wide integers, and a monitor compares every
// result field by field, in order, against the queue of expected phasors.
// ----------------------------------------------------------------------------
module phat_cross_spectrum_normalizer_tb;
  import pcsn_pkg::*;

  localparam int BW   = 24;
  localparam int FB   = 15;
  localparam int LAT  = FB + 6;
  localparam int NRND = 1900;

  typedef struct packed {
    logic signed [BW-1:0] lr;
    logic signed [BW-1:0] li;
    logic signed [BW-1:0] rr;
    logic signed [BW-1:0] ri;
    logic                 last;
  } bin_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic                    zero;
    logic                    last;
  } phasor_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [BW-1:0] in_left_real;
  logic signed [BW-1:0] in_left_imag;
  logic signed [BW-1:0] in_right_real;
  logic signed [BW-1:0] in_right_imag;
  logic in_last_bin;
  logic out_valid;
  logic out_ready;
  logic signed [OUT_W-1:0] out_phase_real;
  logic signed [OUT_W-1:0] out_phase_imag;
  logic out_zero_magnitude;
  logic out_last_out;

  bin_t    pending_bins[$];
  phasor_t expected_phasors[$];
  int      n_errors;
  bit      stim_done;
  int      hold_cycles;

  phat_cross_spectrum_normalizer #(.BIN_BITS(BW), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_left_real(in_left_real), .in_left_imag(in_left_imag),
    .in_right_real(in_right_real), .in_right_imag(in_right_imag),
    .in_last_bin(in_last_bin),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_phase_real(out_phase_real), .out_phase_imag(out_phase_imag),
    .out_zero_magnitude(out_zero_magnitude), .out_last_out(out_last_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Rounded ratio a * 2^FB / sqrt(p), ties away from zero, by binary search.
  function automatic longint unsigned ratio_part(logic [63:0] a, logic [255:0] p);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    logic [255:0] rhs;
    logic [255:0] lhs;
    lo = 0;
    hi = 64'd1 << FB;
    rhs = ({192'd0, a} * {192'd0, a}) << (2 * FB + 2);
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      lhs = {192'd0, 64'(2 * mid - 1)};
      lhs = lhs * lhs * p;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Expected unit phasor of conj(L)*R for one bin.
  function automatic phasor_t phat_weight(bin_t b);
    phasor_t r;
    logic signed [63:0] sre;
    logic signed [63:0] sim;
    logic [63:0] are;
    logic [63:0] aim;
    logic [255:0] pw;
    longint unsigned qre;
    longint unsigned qim;
    sre = 64'(b.lr) * 64'(b.rr) + 64'(b.li) * 64'(b.ri);
    sim = 64'(b.lr) * 64'(b.ri) - 64'(b.li) * 64'(b.rr);
    are = sre[63] ? -sre : sre;
    aim = sim[63] ? -sim : sim;
    pw = {192'd0, are} * {192'd0, are} + {192'd0, aim} * {192'd0, aim};
    r.last = b.last;
    if (pw == 0) begin
      r.re = '0;
      r.im = '0;
      r.zero = 1'b1;
      return r;
    end
    qre = ratio_part(are, pw);
    qim = ratio_part(aim, pw);
    if (qre > SAT_MAX) qre = SAT_MAX;
    if (qim > SAT_MAX) qim = SAT_MAX;
    r.re = sre[63] ? -OUT_W'(qre) : OUT_W'(qre);
    r.im = sim[63] ? -OUT_W'(qim) : OUT_W'(qim);
    r.zero = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic logic signed [BW-1:0] rand_comp();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return {1'b1, {(BW-1){1'b0}}};
    if (sel == 1) return {1'b0, {(BW-1){1'b1}}};
    if (sel == 2) return BW'($signed($urandom_range(0, 64)) - 32);
    if (sel == 3) return '0;
    return BW'($urandom);
  endfunction

  function automatic bin_t mk(int lr, int li, int rr, int ri, bit last);
    bin_t b;
    b.lr = BW'(lr);
    b.li = BW'(li);
    b.rr = BW'(rr);
    b.ri = BW'(ri);
    b.last = last;
    return b;
  endfunction

  // Stimulus: directed corners first, then random bins.
  initial begin
    int mx;
    int mn;
    bin_t b;
    mx = 8388607;
    mn = -8388608;
    n_errors = 0;
    stim_done = 0;
    pending_bins.push_back(mk(0, 0, 0, 0, 0));
    pending_bins.push_back(mk(0, 0, 5, -3, 1));
    pending_bins.push_back(mk(7, 2, 0, 0, 0));
    pending_bins.push_back(mk(mx, mx, mx, mx, 0));
    pending_bins.push_back(mk(mn, mn, mn, mn, 1));
    pending_bins.push_back(mk(mn, mx, mx, mn, 0));
    pending_bins.push_back(mk(mn, 0, mn, 0, 0));
    pending_bins.push_back(mk(mx, 0, mn, 0, 0));
    pending_bins.push_back(mk(0, mn, mx, 0, 1));
    pending_bins.push_back(mk(1, 0, 1, 0, 0));
    pending_bins.push_back(mk(1, 0, -1, 0, 0));
    pending_bins.push_back(mk(1, 0, 0, 1, 0));
    pending_bins.push_back(mk(1, 0, 0, -1, 0));
    pending_bins.push_back(mk(1, 1, 1, 0, 0));
    pending_bins.push_back(mk(3, 4, 4, 3, 0));
    pending_bins.push_back(mk(-1, -1, -1, -1, 1));
    pending_bins.push_back(mk(mx, 1, 1, mx, 0));
    pending_bins.push_back(mk(-2, 1, 1, 2, 0));
    repeat (NRND) begin
      b.lr = rand_comp();
      b.li = rand_comp();
      b.rr = rand_comp();
      b.ri = rand_comp();
      b.last = ($urandom_range(0, 7) == 0);
      pending_bins.push_back(b);
    end
  end

  // Driver: offers queued bins with random gaps.
  always @(posedge clk) begin
    bin_t b;
    int gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_phasors.push_back(phat_weight({in_left_real, in_left_imag,
            in_right_real, in_right_imag, in_last_bin}));
        void'(pending_bins.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pending_bins.size() > (in_valid && in_ready ? 0 : 0) &&
                     pending_bins.size() != 0) begin
          b = pending_bins[0];
          in_valid <= 1'b1;
          in_left_real <= b.lr;
          in_left_imag <= b.li;
          in_right_real <= b.rr;
          in_right_imag <= b.ri;
          in_last_bin <= b.last;
          gap = ($urandom_range(0, 3) == 0) ?
                (($urandom_range(0, 19) == 0) ? $urandom_range(5, 30)
                                               : $urandom_range(0, 2)) : 0;
        end else begin
          in_valid <= 1'b0;
          if (pending_bins.size() == 0) stim_done = 1;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest expected phasor.
  always @(posedge clk) begin
    phasor_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_phasors.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_phasors.pop_front();
          if (out_phase_real !== want.re)
            report_mismatch("phase_real", out_phase_real, want.re);
          if (out_phase_imag !== want.im)
            report_mismatch("phase_imag", out_phase_imag, want.im);
          if (out_zero_magnitude !== want.zero)
            report_mismatch("zero_magnitude", out_zero_magnitude, want.zero);
          if (out_last_out !== want.last)
            report_mismatch("last_out", out_last_out, want.last);
        end
      end
      if (hold_cycles > 0) out_ready <= 1'b0;
      else if ($urandom_range(0, 99) < 8) out_ready <= 1'b0;
      else out_ready <= 1'b1;
    end
  end

  // Long receiver hold-off so that the pipeline fills and stalls its input.
  initial begin
    hold_cycles = 0;
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_cycles = 1;
    repeat (3 * LAT) @(posedge clk);
    hold_cycles = 0;
  end

  // Reset, then wait for the end of the traffic.
  initial begin
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_left_real = '0;
    in_left_imag = '0;
    in_right_real = '0;
    in_right_imag = '0;
    in_last_bin = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && !in_valid && expected_phasors.size() == 0);
    repeat (2 * LAT) @(posedge clk);
    if (n_errors == 0 && expected_phasors.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
